>>> rtl/tchk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tchk_pkg: shared types and constants for the triangle check / Heron area block
// Beat layouts for the side and area channels, field widths, default side width.
// ----------------------------------------------------------------------------
package tchk_pkg;

    localparam int SIDE_W        = 16;  // width of each side field on the port
    localparam int AREA_W        = 37;  // width of the area field on the port
    localparam int SIDE_BITS_DEF = 16;  // default number of side bits in use
    localparam int FRAC_SHIFT    = 12;  // radicand is P * 2^12 -> 8 fraction bits

    typedef struct packed {
        logic signed [SIDE_W-1:0] side_ab;
        logic signed [SIDE_W-1:0] side_ac;
        logic signed [SIDE_W-1:0] side_bc;
    } side_beat_t;

    typedef struct packed {
        logic              is_triangle;
        logic [AREA_W-1:0] area_q8;
    } area_beat_t;

endpackage
`default_nettype wire

>>> rtl/triangle_check_heron_area.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_check_heron_area: triangle check and Heron area, fully pipelined
// Checks three signed sides for a strict triangle and returns the area in Q.8.
// ----------------------------------------------------------------------------
// One side beat in, one area beat out, in order. The block takes a new beat
// every cycle while no area beat is held. The pipeline has one stage for the
// sums and the triangle check, two multiplier stages, one stage to assemble
// the 64-bit product P, then one stage per root bit of floor(sqrt(P * 4096)),
// a single compare and subtract each. The last root stage is the output
// register. A stall on the area channel freezes the whole pipeline while the
// output beat waits, so side_stall is high exactly when an area beat is held.
// Each side is taken from the low SIDE_BITS bits of its field and
// sign-extended; any nonpositive side or a degenerate triple gives
// is_triangle = 0 and area_q8 = 0.
// ----------------------------------------------------------------------------
module triangle_check_heron_area #(
    parameter int SIDE_BITS = tchk_pkg::SIDE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 side_valid,
    output logic                 side_stall,
    input  tchk_pkg::side_beat_t side_data,
    output logic                 area_valid,
    input  logic                 area_stall,
    output tchk_pkg::area_beat_t area_data
);
    import tchk_pkg::*;

    localparam int N       = SIDE_BITS;
    localparam int SUM_W   = N + 2;            // signed sums of three sides
    localparam int S1_W    = N + 1;            // a+b+c
    localparam int T_W     = N;                // b+c-a and friends
    localparam int X_W     = S1_W + T_W;       // (a+b+c)(b+c-a)
    localparam int Y_W     = 2 * T_W;          // (a+c-b)(a+b-c)
    localparam int PP_W    = X_W + N;          // partial products x * y half
    localparam int P_W     = 4 * N;            // 16 * area^2 fits below 2^(4N-1)
    localparam int RAD_W   = P_W + FRAC_SHIFT; // radicand P * 4096
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int EXT_W   = (ROOT_W > AREA_W) ? ROOT_W : AREA_W;

    // Global advance: everything moves unless a finished beat is held.
    logic adv;
    assign adv        = !(area_valid && area_stall);
    assign side_stall = !adv;

    // ------------------------------------------------------------------
    // Stage 1: sign extension, the four Heron factors, triangle check.
    // Invalid triples are zeroed here so P and the root come out as zero.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] a_s, b_s, c_s;
    logic signed [SUM_W-1:0] sum_s, da_s, db_s, dc_s;
    logic                    ok_s;

    assign a_s   = SUM_W'(signed'(side_data.side_ab[N-1:0]));
    assign b_s   = SUM_W'(signed'(side_data.side_ac[N-1:0]));
    assign c_s   = SUM_W'(signed'(side_data.side_bc[N-1:0]));
    assign sum_s = a_s + b_s + c_s;
    assign da_s  = b_s + c_s - a_s;
    assign db_s  = a_s + c_s - b_s;
    assign dc_s  = a_s + b_s - c_s;
    // pairwise inequalities are the same as all three differences positive
    assign ok_s  = (a_s > 0) && (b_s > 0) && (c_s > 0) &&
                   (da_s > 0) && (db_s > 0) && (dc_s > 0);

    logic            v1_reg, ok1_reg;
    logic [S1_W-1:0] s1_reg, s1_next;
    logic [T_W-1:0]  t1_reg, t2_reg, t3_reg;
    logic [T_W-1:0]  t1_next, t2_next, t3_next;

    always_comb
    begin
        s1_next = ok_s ? sum_s[S1_W-1:0] : '0;
        t1_next = ok_s ? da_s[T_W-1:0]   : '0;
        t2_next = ok_s ? db_s[T_W-1:0]   : '0;
        t3_next = ok_s ? dc_s[T_W-1:0]   : '0;
    end

    // ------------------------------------------------------------------
    // Stage 2: two pairwise products.
    // ------------------------------------------------------------------
    logic            v2_reg, ok2_reg;
    logic [X_W-1:0]  x2_reg, x2_next;
    logic [Y_W-1:0]  y2_reg, y2_next;

    assign x2_next = X_W'(s1_reg) * X_W'(t1_reg);
    assign y2_next = Y_W'(t2_reg) * Y_W'(t3_reg);

    // ------------------------------------------------------------------
    // Stage 3: x times each half of y.
    // ------------------------------------------------------------------
    logic            v3_reg, ok3_reg;
    logic [PP_W-1:0] pl3_reg, pl3_next;
    logic [PP_W-1:0] ph3_reg, ph3_next;

    assign pl3_next = PP_W'(x2_reg) * PP_W'(y2_reg[N-1:0]);
    assign ph3_next = PP_W'(x2_reg) * PP_W'(y2_reg[Y_W-1:N]);

    // ------------------------------------------------------------------
    // Stage 4: P = ph * 2^N + pl.
    // ------------------------------------------------------------------
    logic            v4_reg, ok4_reg;
    logic [P_W-1:0]  p4_reg, p4_next;

    assign p4_next = P_W'({ph3_reg, {N{1'b0}}}) + P_W'(pl3_reg);

    // ------------------------------------------------------------------
    // Root stages: one root bit per stage, restoring digit recurrence.
    // The radicand shifts left two bits a stage; its top pair feeds the
    // partial remainder.
    // ------------------------------------------------------------------
    logic              sq_v_reg    [ROOT_W];
    logic              sq_ok_reg   [ROOT_W];
    logic [RAD_W-1:0]  sq_rad_reg  [ROOT_W];
    logic [ROOT_W-1:0] sq_root_reg [ROOT_W];
    logic [REM_W-1:0]  sq_rem_reg  [ROOT_W];

    logic              sq_v_next    [ROOT_W];
    logic              sq_ok_next   [ROOT_W];
    logic [RAD_W-1:0]  sq_rad_next  [ROOT_W];
    logic [ROOT_W-1:0] sq_root_next [ROOT_W];
    logic [REM_W-1:0]  sq_rem_next  [ROOT_W];

    always_comb
    begin
        logic [RAD_W-1:0]  rad_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W-1:0]  rem_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        for (int k = 0; k < ROOT_W; k++)
        begin
            if (k == 0)
            begin
                sq_v_next[k]  = v4_reg;
                sq_ok_next[k] = ok4_reg;
                rad_in        = {p4_reg, {FRAC_SHIFT{1'b0}}};
                root_in       = '0;
                rem_in        = '0;
            end
            else
            begin
                sq_v_next[k]  = sq_v_reg[k-1];
                sq_ok_next[k] = sq_ok_reg[k-1];
                rad_in        = sq_rad_reg[k-1];
                root_in       = sq_root_reg[k-1];
                rem_in        = sq_rem_reg[k-1];
            end
            rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
            trial  = {root_in, 2'b01};
            if (rem_sh >= trial)
            begin
                sq_rem_next[k]  = rem_sh - trial;
                sq_root_next[k] = {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_next[k]  = rem_sh;
                sq_root_next[k] = {root_in[ROOT_W-2:0], 1'b0};
            end
            sq_rad_next[k] = {rad_in[RAD_W-3:0], 2'b00};
        end
    end

    // ------------------------------------------------------------------
    // Valid bits: reset, advance with the pipeline.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            for (int k = 0; k < ROOT_W; k++)
            begin
                sq_v_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg <= side_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            for (int k = 0; k < ROOT_W; k++)
            begin
                sq_v_reg[k] <= sq_v_next[k];
            end
        end
    end

    // Payload: no reset.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok1_reg <= ok_s;
            s1_reg  <= s1_next;
            t1_reg  <= t1_next;
            t2_reg  <= t2_next;
            t3_reg  <= t3_next;
            ok2_reg <= ok1_reg;
            x2_reg  <= x2_next;
            y2_reg  <= y2_next;
            ok3_reg <= ok2_reg;
            pl3_reg <= pl3_next;
            ph3_reg <= ph3_next;
            ok4_reg <= ok3_reg;
            p4_reg  <= p4_next;
            for (int k = 0; k < ROOT_W; k++)
            begin
                sq_ok_reg[k]   <= sq_ok_next[k];
                sq_rad_reg[k]  <= sq_rad_next[k];
                sq_root_reg[k] <= sq_root_next[k];
                sq_rem_reg[k]  <= sq_rem_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output beat straight from the last root stage.
    // ------------------------------------------------------------------
    logic [EXT_W-1:0] root_ext;
    assign root_ext = EXT_W'(sq_root_reg[ROOT_W-1]);

    assign area_valid            = sq_v_reg[ROOT_W-1];
    assign area_data.is_triangle = sq_ok_reg[ROOT_W-1];
    assign area_data.area_q8     = root_ext[AREA_W-1:0];

endmodule
`default_nettype wire

>>> rtl/tchk_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tchk_checker: port-level checks for triangle_check_heron_area
// Watches both channels; bound to the top level below.
// ----------------------------------------------------------------------------
module tchk_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 side_valid,
    input  logic                 side_stall,
    input  tchk_pkg::side_beat_t side_data,
    input  logic                 area_valid,
    input  logic                 area_stall,
    input  tchk_pkg::area_beat_t area_data
);
    import tchk_pkg::*;

    logic unused_side;
    assign unused_side = side_valid ^ (^side_data);

    // held beat stays put
    a_area_hold: assert property (@(posedge clk) disable iff (!rst_n)
        area_valid && area_stall |=> area_valid && $stable(area_data))
        else $error("area beat changed while stalled");

    // input back-pressure only comes from a held output beat
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        side_stall |-> area_valid && area_stall)
        else $error("side_stall without a held area beat");

    // non-triangles report zero area
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        area_valid && !area_data.is_triangle |-> area_data.area_q8 == '0)
        else $error("nonzero area for a non-triangle");

    // a real integer triangle has P >= 1, so the Q.8 area is at least 64
    a_valid_min: assert property (@(posedge clk) disable iff (!rst_n)
        area_valid && area_data.is_triangle |-> area_data.area_q8 >= AREA_W'(64))
        else $error("triangle area below the smallest possible value");

endmodule

bind triangle_check_heron_area tchk_checker u_tchk_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .side_valid (side_valid),
    .side_stall (side_stall),
    .side_data  (side_data),
    .area_valid (area_valid),
    .area_stall (area_stall),
    .area_data  (area_data)
);
`default_nettype wire

>>> bench/tb_triangle_check_heron_area.sv
// ----------------------------------------------------------------------------
// tb_triangle_check_heron_area: self-checking bench for triangle check / Heron area
// Drives side beats with random gaps and area-side stalls. Every accepted side
// beat is run through an exact integer Heron predictor. Every area beat is
// checked in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_triangle_check_heron_area;

    import tchk_pkg::*;

    // Side width in use by the instance (default parameter) and the pipeline
    // depth of the block: sums, two multiply stages,
    // product assembly, then one stage per root bit.
    localparam int SIDE_USE     = SIDE_BITS_DEF;
    localparam int PIPE_LATENCY = 4 + 2*SIDE_USE + FRAC_SHIFT/2;
    localparam int SETTLE_WAIT  = PIPE_LATENCY + 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 36;
    localparam int SHOW_MAX     = 10;
    localparam int SMAX         = 32767;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       side_valid;
    logic       side_stall;
    side_beat_t side_data;
    logic       area_valid;
    logic       area_stall = 1'b0;
    area_beat_t area_data;

    // Predicted area beats, oldest first.
    area_beat_t area_expect_q[$];

    // When set, neither side idles: back-to-back beats at full rate.
    logic calm_window;

    // Counters owned by the watchdog and the result checker start at zero.
    int cycle_count    = 0;
    int beats_sent;
    int areas_checked  = 0;
    int triangles_seen = 0;
    int rejects_seen   = 0;
    int stall_cycles   = 0;
    int mismatch_count = 0;
    int orphan_count   = 0;

    triangle_check_heron_area DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .side_valid (side_valid),
        .side_stall (side_stall),
        .side_data  (side_data),
        .area_valid (area_valid),
        .area_stall (area_stall),
        .area_data  (area_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Take the low SIDE_USE bits of a field and sign-extend them.
    function automatic longint signed side_len(input logic [SIDE_W-1:0] raw);
        logic signed [SIDE_USE-1:0] low;
        low = raw[SIDE_USE-1:0];
        return longint'(low);
    endfunction

    // Exact Heron area in Q.8: floor(sqrt(P * 4096)),
    // P = (a+b+c)(b+c-a)(a+c-b)(a+b-c).
    // The root is built bit by bit on an 80-bit radicand, so the shift by 12
    // never overflows.
    function automatic area_beat_t heron_area_q8(input side_beat_t beat);
        longint signed a;
        longint signed b;
        longint signed c;
        logic [63:0]   prod;
        logic [79:0]   radicand;
        logic [79:0]   square;
        logic [39:0]   root;
        logic [39:0]   trial;
        area_beat_t    res;
        a   = side_len(beat.side_ab);
        b   = side_len(beat.side_ac);
        c   = side_len(beat.side_bc);
        res = '0;
        if (a > 0 && b > 0 && c > 0 && a + b > c && b + c > a && a + c > b)
        begin
            // Each factor is positive here, and the product stays below 2^63.
            prod     = (a + b + c) * (b + c - a) * (a + c - b) * (a + b - c);
            radicand = {4'b0, prod, 12'b0};
            root     = '0;
            for (int i = 39; i >= 0; i--)
            begin
                trial  = root | (40'd1 << i);
                square = trial * trial;
                if (square <= radicand)
                    root = trial;
            end
            res.is_triangle = 1'b1;
            res.area_q8     = root[AREA_W-1:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic side_beat_t sides(input int ab, input int ac, input int bc);
        side_beat_t beat;
        beat.side_ab = ab[SIDE_W-1:0];
        beat.side_ac = ac[SIDE_W-1:0];
        beat.side_bc = bc[SIDE_W-1:0];
        return beat;
    endfunction

    // A well-formed triangle with random sides; the third side lands in a
    // random field. Sometimes all sides are small, to reach tiny areas.
    function automatic side_beat_t rand_triangle();
        int top;
        int a;
        int b;
        int c;
        int lo;
        int hi;
        top = ($urandom_range(0, 99) < 25) ? 15 : SMAX;
        a   = $urandom_range(1, top);
        b   = $urandom_range(1, top);
        lo  = (a > b ? a - b : b - a) + 1;
        hi  = (a + b - 1 < SMAX) ? a + b - 1 : SMAX;
        c   = $urandom_range(lo, hi);
        case ($urandom_range(0, 2))
            0:       return sides(c, a, b);
            1:       return sides(a, c, b);
            default: return sides(a, b, c);
        endcase
    endfunction

    // A flat triple: one side equals the sum of the other two.
    function automatic side_beat_t rand_flat();
        int a;
        int b;
        a = $urandom_range(1, SMAX - 1);
        b = $urandom_range(1, SMAX - a);
        case ($urandom_range(0, 2))
            0:       return sides(a + b, a, b);
            1:       return sides(a, a + b, b);
            default: return sides(a, b, a + b);
        endcase
    endfunction

    // Send one side beat. Entered just after a rising edge (or at start);
    // returns at the rising edge where the beat is taken. Valid is left high,
    // so a following beat goes out without a bubble unless an idle gap is drawn.
    task automatic send_side(input side_beat_t beat);
        while (!calm_window && $urandom_range(0, 99) < IDLE_PCT)
        begin
            @(negedge clk);
            side_valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        side_valid <= 1'b1;
        side_data  <= beat;
        do
            @(posedge clk);
        while (side_stall);
        area_expect_q.push_back(heron_area_q8(beat));
        beats_sent++;
    endtask

    // Drop valid and hold off until every predicted area beat has come back.
    task automatic drain_areas();
        @(negedge clk);
        side_valid <= 1'b0;
        while (area_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes: most negative, zero, minus one, one, most positive.
    task automatic test_field_extremes();
        send_side(sides(SMAX, SMAX, SMAX));         // largest equilateral
        send_side(sides(-32768, -32768, -32768));
        send_side(sides(0, 0, 0));
        send_side(sides(-1, -1, -1));
        send_side(sides(1, 1, 1));                  // smallest valid triangle
        send_side(sides(SMAX, SMAX, 1));
        send_side(sides(1, SMAX, SMAX));
        send_side(sides(SMAX, 1, SMAX));
        send_side(sides(-32768, SMAX, SMAX));       // one negative side
        send_side(sides(SMAX, 0, SMAX));            // one zero side
        send_side(sides(SMAX, SMAX, -1));
    endtask

    // Flat triples with the long side in each field, plus zero with a pair of equals.
    task automatic test_flat_triples();
        send_side(sides(1, 2, 3));
        send_side(sides(3, 1, 2));
        send_side(sides(2, 3, 1));
        send_side(sides(16384, 16383, SMAX));
        send_side(sides(0, 5, 5));
    endtask

    // Known shapes: right triangle, isosceles, near-flat slivers.
    task automatic test_known_shapes();
        send_side(sides(3, 4, 5));
        send_side(sides(5, 5, 8));
        send_side(sides(2, 2, 3));
        send_side(sides(100, 200, 250));
        send_side(sides(16384, 16384, SMAX));
        send_side(sides(SMAX, SMAX, 32766));
        drain_areas();
    endtask

    // Mostly well-formed triangles, some flat triples, some raw noise.
    task automatic test_random_mix(input int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_side(rand_triangle());
            else if (pick < 80)
                send_side(rand_flat());
            else
                send_side(side_beat_t'({$urandom, 16'($urandom)}));
        end
    endtask

    // Full-rate stretch: no sender gaps, no area stalls.
    task automatic test_back_to_back(input int count);
        calm_window = 1'b1;
        for (int n = 0; n < count; n++)
            send_side(rand_triangle());
        calm_window = 1'b0;
    endtask

    // Bursts with a full drain between them, so the pipe empties and refills.
    task automatic test_drain_refill(input int bursts);
        for (int k = 0; k < bursts; k++)
        begin
            test_random_mix($urandom_range(5, 15));
            drain_areas();
        end
    endtask

    // ------------------------------------------------------------------
    // Area stall driver: random stalls except during a calm window
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (calm_window)
            area_stall <= 1'b0;
        else
            area_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Result checker: each taken area beat against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_area
        area_beat_t want;
        if (rst_n && area_valid && area_stall)
            stall_cycles++;
        if (rst_n && area_valid && !area_stall)
        begin
            if (area_expect_q.size() == 0)
            begin
                orphan_count++;
                if (orphan_count + mismatch_count <= SHOW_MAX)
                    $display("unexpected area beat: tri=%0b area=%0d",
                             area_data.is_triangle, area_data.area_q8);
            end
            else
            begin
                want = area_expect_q.pop_front();
                areas_checked++;
                if (want.is_triangle)
                    triangles_seen++;
                else
                    rejects_seen++;
                if (area_data.is_triangle !== want.is_triangle ||
                    area_data.area_q8 !== want.area_q8)
                begin
                    mismatch_count++;
                    if (orphan_count + mismatch_count <= SHOW_MAX)
                        $display({"area beat %0d mismatch: exp tri=%0b area=%0d,",
                                  " got tri=%0b area=%0d"},
                                 areas_checked, want.is_triangle, want.area_q8,
                                 area_data.is_triangle, area_data.area_q8);
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d area beats outstanding",
                     cycle_count, area_expect_q.size());
            $display("** triangle_check_heron_area: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        side_valid     = 1'b0;
        side_data      = '0;
        calm_window    = 1'b0;
        beats_sent     = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_flat_triples();
        test_known_shapes();
        test_random_mix(300);
        test_back_to_back(120);
        test_drain_refill(8);
        test_random_mix(40);

        // All beats sent: let the pipe empty, then watch for strays.
        drain_areas();
        repeat (SETTLE_WAIT) @(posedge clk);

        $display("run covered %0d side beats in %0d cycles: %0d triangles, %0d rejected",
                 beats_sent, cycle_count, triangles_seen, rejects_seen);
        $display("area stalls held a beat for %0d cycles; %0d mismatches, %0d unexpected",
                 stall_cycles, mismatch_count, orphan_count);
        if (mismatch_count == 0 && orphan_count == 0 && area_expect_q.size() == 0)
            $display("** triangle_check_heron_area: PASSED **");
        else
            $display("** triangle_check_heron_area: FAILED **");
        $finish;
    end

endmodule
